// ===== rtl/core/ddc_pkg.sv =====
// ----------------------------------------------------------------------------
// Drive distance controller package
// Shared widths, constants, register indexes and stage bundles.
// ----------------------------------------------------------------------------
package ddc_pkg;

    // Field widths.
    localparam int TGT_DIST_W = 21;
    localparam int HEADING_W  = 24;
    localparam int GAIN_W     = 16;
    localparam int CEIL_W     = 7;
    localparam int POS_W      = 20;
    localparam int DRIVE_OUT_W = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Internal arithmetic widths.
    localparam int ERR_W     = TGT_DIST_W + 1;
    localparam int DRIVE_W   = ERR_W + GAIN_W + 1;
    localparam int HDIFF_W   = HEADING_W + 1;
    localparam int HTERM_W   = HDIFF_W + GAIN_W + 1;
    localparam int SUM_W     = HTERM_W + 1;
    localparam int FRAC_BITS = 12;
    localparam int RAMP_W    = 8;
    localparam int SETTLE_W  = 3;

    // Controller constants.
    localparam logic [RAMP_W-1:0]   RAMP_START   = 8'd40;
    localparam logic [RAMP_W-1:0]   RAMP_STEP    = 8'd4;
    localparam logic [SETTLE_W-1:0] SETTLE_TICKS = 3'd5;
    localparam int                  DRIVE_MAX    = 127;

    // Register reset values.
    localparam logic [CEIL_W-1:0] CEIL_RESET = 7'd127;
    localparam logic [GAIN_W-1:0] PGAIN_RESET = 16'd614;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_DISTANCE = 3'd0,
        CFG_TARGET_HEADING  = 3'd1,
        CFG_HEADING_GAIN    = 3'd2,
        CFG_RAMP_CEILING    = 3'd3,
        CFG_POSITION_GAIN   = 3'd4
    } t_cfg_index;

    // Configuration register bundle.
    typedef struct packed {
        logic signed [TGT_DIST_W-1:0] target_distance;
        logic signed [HEADING_W-1:0]  target_heading;
        logic [GAIN_W-1:0]            heading_gain;
        logic [CEIL_W-1:0]            ramp_ceiling;
        logic [GAIN_W-1:0]            position_gain;
    } t_cfg;

    // Products and flags handed from the multiply stage to the output stage.
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic signed [HTERM_W-1:0] hterm;
        logic                      forward;
        logic                      settle_hit;
        logic                      begin_req;
    } t_prod;

endpackage

// ===== rtl/core/ddc_product_stage.sv =====
// ----------------------------------------------------------------------------
// Drive distance controller multiply stage
// Forms the distance and heading errors, multiplies them by their gains and
// registers the products together with the settling flag of the beat.
// ----------------------------------------------------------------------------
module ddc_product_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_valid,
    input  ddc_pkg::t_cfg                 i_cfg,
    input  logic                          i_begin_req,
    input  logic [ddc_pkg::POS_W-1:0]     i_position_before,
    input  logic [ddc_pkg::POS_W-1:0]     i_position_after,
    input  logic signed [ddc_pkg::HEADING_W-1:0] i_heading,
    output logic                          o_valid,
    output ddc_pkg::t_prod                o_prod
);
    import ddc_pkg::*;

    logic                      forward;
    logic signed [ERR_W-1:0]   tgt_ext;
    logic signed [ERR_W-1:0]   mag;
    logic signed [ERR_W-1:0]   err_raw;
    logic signed [ERR_W-1:0]   err;
    logic signed [HDIFF_W-1:0] hdiff;
    logic signed [POS_W:0]     pdiff;
    logic                      r_valid;
    t_prod                     r_prod;
    t_prod                     n_prod;

    // Signed distance error; a zero target counts as forward travel.
    always_comb begin
        forward = !i_cfg.target_distance[TGT_DIST_W-1];
        tgt_ext = ERR_W'(i_cfg.target_distance);
        mag     = forward ? tgt_ext : -tgt_ext;
        err_raw = mag - $signed({2'b00, i_position_after});
        err     = forward ? err_raw : -err_raw;
        hdiff   = HDIFF_W'(i_heading) - HDIFF_W'(i_cfg.target_heading);
        pdiff   = $signed({1'b0, i_position_after}) - $signed({1'b0, i_position_before});
    end

    // Gain products at full product width and the settling test on the samples.
    always_comb begin
        n_prod.drive      = DRIVE_W'(err) * DRIVE_W'($signed({1'b0, i_cfg.position_gain}));
        n_prod.hterm      = HTERM_W'(hdiff) * HTERM_W'($signed({1'b0, i_cfg.heading_gain}));
        n_prod.forward    = forward;
        n_prod.settle_hit = (pdiff == '0) || (pdiff == (POS_W+1)'(1))
                            || (pdiff == -(POS_W+1)'(1));
        n_prod.begin_req  = i_begin_req;
    end

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

// ===== rtl/core/ddc_output_stage.sv =====
// ----------------------------------------------------------------------------
// Drive distance controller output stage
// Applies the ramp clip, mixes in the heading term, scales and saturates the
// commands, and keeps the ramp, settling and finished state of the move.
// ----------------------------------------------------------------------------
module ddc_output_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_valid,
    input  logic [ddc_pkg::CEIL_W-1:0]    i_ramp_ceiling,
    input  ddc_pkg::t_prod                i_prod,
    output logic                          o_valid,
    output logic signed [ddc_pkg::DRIVE_OUT_W-1:0] o_left_drive,
    output logic signed [ddc_pkg::DRIVE_OUT_W-1:0] o_right_drive,
    output logic                          o_move_done
);
    import ddc_pkg::*;

    localparam int SCALED_W = SUM_W - FRAC_BITS;

    logic [RAMP_W-1:0]   r_ramp;
    logic [RAMP_W-1:0]   n_ramp;
    logic [SETTLE_W-1:0] r_settle;
    logic [SETTLE_W-1:0] n_settle;
    logic                r_finished;
    logic                n_finished;
    logic                r_valid;
    logic signed [DRIVE_OUT_W-1:0] r_left;
    logic signed [DRIVE_OUT_W-1:0] r_right;
    logic                r_done;
    logic signed [DRIVE_OUT_W-1:0] n_left;
    logic signed [DRIVE_OUT_W-1:0] n_right;
    logic                n_done;

    logic [RAMP_W-1:0]         ramp_cur;
    logic [SETTLE_W-1:0]       settle_cur;
    logic                      fin_cur;
    logic signed [DRIVE_W-1:0] lim;
    logic signed [DRIVE_W-1:0] drive_clip;
    logic signed [SUM_W-1:0]   sum_left;
    logic signed [SUM_W-1:0]   sum_right;
    logic signed [DRIVE_OUT_W-1:0] cmd_left;
    logic signed [DRIVE_OUT_W-1:0] cmd_right;

    // Divide by 2^FRAC_BITS toward zero, then saturate to the drive range.
    function automatic logic signed [DRIVE_OUT_W-1:0] finish_cmd(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0]    biased;
        logic signed [SCALED_W-1:0] q;
        logic signed [DRIVE_OUT_W-1:0] res;
        biased = v[SUM_W-1] ? v + SUM_W'((1 << FRAC_BITS) - 1) : v;
        q      = SCALED_W'(biased >>> FRAC_BITS);
        if (q > SCALED_W'(DRIVE_MAX)) begin
            res = DRIVE_OUT_W'(DRIVE_MAX);
        end else if (q < -SCALED_W'(DRIVE_MAX)) begin
            res = -DRIVE_OUT_W'(DRIVE_MAX);
        end else begin
            res = DRIVE_OUT_W'(q);
        end
        return res;
    endfunction

    // Ramp clip on the side of travel and heading mix.
    always_comb begin
        ramp_cur   = i_prod.begin_req ? RAMP_START : r_ramp;
        settle_cur = i_prod.begin_req ? '0 : r_settle;
        fin_cur    = i_prod.begin_req ? 1'b0 : r_finished;
        lim        = $signed(DRIVE_W'({ramp_cur, FRAC_BITS'(0)}));
        drive_clip = i_prod.drive;
        if (i_prod.forward) begin
            if (i_prod.drive > lim) begin
                drive_clip = lim;
            end
        end else begin
            if (i_prod.drive < -lim) begin
                drive_clip = -lim;
            end
        end
        sum_left  = SUM_W'(drive_clip) - SUM_W'(i_prod.hterm);
        sum_right = SUM_W'(drive_clip) + SUM_W'(i_prod.hterm);
        cmd_left  = finish_cmd(sum_left);
        cmd_right = finish_cmd(sum_right);
    end

    // Move state update and result selection.
    always_comb begin
        n_ramp     = ramp_cur;
        n_settle   = settle_cur;
        n_finished = fin_cur;
        n_left     = '0;
        n_right    = '0;
        n_done     = 1'b1;
        if (!fin_cur) begin
            n_settle = settle_cur + SETTLE_W'(i_prod.settle_hit);
            if (ramp_cur < RAMP_W'(i_ramp_ceiling)) begin
                n_ramp = ramp_cur + RAMP_STEP;
            end
            if (n_settle >= SETTLE_TICKS) begin
                n_finished = 1'b1;
            end else begin
                n_left  = cmd_left;
                n_right = cmd_right;
                n_done  = 1'b0;
            end
        end
    end

    // Move state registers, advanced once per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp     <= RAMP_START;
            r_settle   <= '0;
            r_finished <= 1'b0;
        end else if (i_load && i_valid) begin
            r_ramp     <= n_ramp;
            r_settle   <= n_settle;
            r_finished <= n_finished;
        end
    end

    // Result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_done  <= n_done;
        end
    end

    assign o_valid       = r_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;
    assign o_move_done   = r_done;

endmodule

// ===== rtl/core/drive_distance_controller_core.sv =====
// An accepted input beat is held in the input register, which feeds the
// multiply stage, which feeds the output stage that presents its result beat.
// Throughput: one beat per cycle, stalls come only from the output channel.
// Reset clears all valids, loads the ramp limit with 40, clears the settle
// count and finished flag, and sets the registers to their documented reset
// values.
// ----------------------------------------------------------------------------
// Drive distance controller core
// Proportional drive controller with a ramped clip and heading correction:
// an input register, a multiply stage and an output stage with the state.
// ----------------------------------------------------------------------------
module drive_distance_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ddc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ddc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_begin_req,
    input  logic [ddc_pkg::POS_W-1:0]             i_position_before,
    input  logic [ddc_pkg::POS_W-1:0]             i_position_after,
    input  logic signed [ddc_pkg::HEADING_W-1:0]  i_heading,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ddc_pkg::DRIVE_OUT_W-1:0] o_left_drive,
    output logic signed [ddc_pkg::DRIVE_OUT_W-1:0] o_right_drive,
    output logic                                  o_move_done
);
    import ddc_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_in_valid;
    logic                   r_begin_req;
    logic [POS_W-1:0]       r_position_before;
    logic [POS_W-1:0]       r_position_after;
    logic signed [HEADING_W-1:0] r_heading;
    logic                   prod_valid;
    t_prod                  prod;
    logic                   out_ready;
    logic                   prod_ready;
    logic                   in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_distance <= '0;
            r_cfg.target_heading  <= '0;
            r_cfg.heading_gain    <= '0;
            r_cfg.ramp_ceiling    <= CEIL_RESET;
            r_cfg.position_gain   <= PGAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_DISTANCE: r_cfg.target_distance <= i_cfg_data[TGT_DIST_W-1:0];
                CFG_TARGET_HEADING:  r_cfg.target_heading  <= i_cfg_data[HEADING_W-1:0];
                CFG_HEADING_GAIN:    r_cfg.heading_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_RAMP_CEILING:    r_cfg.ramp_ceiling    <= i_cfg_data[CEIL_W-1:0];
                CFG_POSITION_GAIN:   r_cfg.position_gain   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow: a stage loads when it is empty or its contents move on.
    assign out_ready  = !o_out_valid || !i_out_stall;
    assign prod_ready = !prod_valid || out_ready;
    assign in_ready   = !r_in_valid || prod_ready;
    assign o_in_stall = !in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_begin_req       <= i_begin_req;
            r_position_before <= i_position_before;
            r_position_after  <= i_position_after;
            r_heading         <= i_heading;
        end
    end

    // Error and gain products.
    ddc_product_stage u_product (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (prod_ready),
        .i_valid           (r_in_valid),
        .i_cfg             (r_cfg),
        .i_begin_req       (r_begin_req),
        .i_position_before (r_position_before),
        .i_position_after  (r_position_after),
        .i_heading         (r_heading),
        .o_valid           (prod_valid),
        .o_prod            (prod)
    );

    // Clip, mix, saturate and move state.
    ddc_output_stage u_output (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (out_ready),
        .i_valid        (prod_valid),
        .i_ramp_ceiling (r_cfg.ramp_ceiling),
        .i_prod         (prod),
        .o_valid        (o_out_valid),
        .o_left_drive   (o_left_drive),
        .o_right_drive  (o_right_drive),
        .o_move_done    (o_move_done)
    );

    // A finished move always reports zero commands.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_move_done |-> o_left_drive == '0 && o_right_drive == '0)
        else $error("done beat with nonzero command");

    // Saturation never yields the most negative code.
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left_drive != -8'sd128 && o_right_drive != -8'sd128)
        else $error("command outside saturation range");

    // Input is held off only when every stage is full and the output is stalled.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall && prod_valid && r_in_valid)
        else $error("input stalled with room in the pipeline");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule
